// ----- rtl/bxavg_pkg.sv -----
package bxavg_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_SHRINK_DEF = 16;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 12;
  localparam int CFG_SF_W   = 5;
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 16;
  localparam int LANES      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHRINK = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // what the shared divider works on
  typedef enum logic [1:0] {
    SEL_RES   = 2'd0,
    SEL_CFG_A = 2'd1,
    SEL_CFG_B = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     take_ok;
    logic     div_start;
    div_sel_t div_sel;
    logic     cfg_latch;
    logic     store_a;
    logic     store_b;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last_pend;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/bxavg_div.sv -----
module bxavg_div #(
  parameter int N = 16,
  parameter int D = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [bxavg_pkg::LANES-1:0][N-1:0]    dividend,
  input  logic [D-1:0]                          divisor,
  output logic                                  done,
  output logic [bxavg_pkg::LANES-1:0][N-1:0]    quotient,
  output logic [bxavg_pkg::LANES-1:0][D-1:0]    remainder
);
  import bxavg_pkg::*;

  localparam int CNT_W = $clog2(N + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D-1:0]     dvs;
  logic [LANES-1:0][N-1:0] quo;
  logic [LANES-1:0][D-1:0] rem;
  logic [LANES-1:0][N-1:0] quo_next;
  logic [LANES-1:0][D-1:0] rem_next;

  // one restoring step per lane and cycle
  always_comb begin
    logic [D:0] sh;
    logic       ge;
    for (int i = 0; i < LANES; i++) begin
      sh = {rem[i], quo[i][N-1]};
      ge = (sh >= {1'b0, dvs});
      if (ge) begin
        rem_next[i] = D'(sh - {1'b0, dvs});
      end else begin
        rem_next[i] = sh[D-1:0];
      end
      quo_next[i] = {quo[i][N-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(N);
      done <= 1'b0;
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      busy <= (cnt != CNT_W'(1));
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- rtl/bxavg_ctrl.sv -----
module bxavg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  bxavg_pkg::dp_stat_t stat,
  output bxavg_pkg::dp_cmd_t  cmd
);
  import bxavg_pkg::*;

  typedef enum logic [6:0] {
    ST_RUN        = 7'b0000001,
    ST_RDIV       = 7'b0000010,
    ST_RLOAD      = 7'b0000100,
    ST_CFG_LATCH  = 7'b0001000,
    ST_CFG_START  = 7'b0010000,
    ST_CFG_WAIT_A = 7'b0100000,
    ST_CFG_WAIT_B = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_RUN: begin
        cmd.take_ok = !stat.last_pend;
        if (stat.last_pend) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_RES;
          state_next    = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (stat.div_done) begin
          state_next = ST_RLOAD;
        end
      end
      ST_RLOAD: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_RUN;
        end
      end
      ST_CFG_LATCH: begin
        cmd.cfg_latch = 1'b1;
        state_next    = ST_CFG_START;
      end
      ST_CFG_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_CFG_A;
        state_next    = ST_CFG_WAIT_A;
      end
      ST_CFG_WAIT_A: begin
        cmd.div_sel = SEL_CFG_B;
        if (stat.div_done) begin
          cmd.store_a   = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = ST_CFG_WAIT_B;
        end
      end
      ST_CFG_WAIT_B: begin
        if (stat.div_done) begin
          cmd.store_b = 1'b1;
          state_next  = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
    // any register write restarts the size recompute
    if (cfg_we) begin
      state_next = ST_CFG_LATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/bxavg_dp.sv -----
module bxavg_dp #(
  parameter int MAX_WIDTH  = bxavg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SHRINK = bxavg_pkg::MAX_SHRINK_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bxavg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bxavg_pkg::PIX_W-1:0]         red_in,
  input  logic [bxavg_pkg::PIX_W-1:0]         green_in,
  input  logic [bxavg_pkg::PIX_W-1:0]         blue_in,
  input  logic                                frame_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bxavg_pkg::PIX_W-1:0]         red_avg,
  output logic [bxavg_pkg::PIX_W-1:0]         green_avg,
  output logic [bxavg_pkg::PIX_W-1:0]         blue_avg,
  output logic [bxavg_pkg::POS_W-1:0]         out_column,
  output logic [bxavg_pkg::POS_W-1:0]         out_row,
  output logic                                frame_done,
  input  bxavg_pkg::dp_cmd_t                  cmd,
  output bxavg_pkg::dp_stat_t                 stat
);
  import bxavg_pkg::*;

  localparam int DIM_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
  localparam int S_W   = $clog2(MAX_SHRINK + 1);
  localparam int PH_W  = (MAX_SHRINK > 1) ? $clog2(MAX_SHRINK) : 1;
  localparam int AR_W  = 2 * S_W;
  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DIVN  = (CMP_W > SUM_W) ? CMP_W : SUM_W;
  localparam int MEM_W = LANES * SUM_W;

  // configuration registers
  logic [CFG_SF_W-1:0]  shrink_reg;
  logic [CFG_DIM_W-1:0] width_reg;
  logic [CFG_DIM_W-1:0] height_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      shrink_reg <= CFG_SF_W'(1);
      width_reg  <= CFG_DIM_W'(1);
      height_reg <= CFG_DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SHRINK: shrink_reg <= cfg_data[CFG_SF_W-1:0];
        REG_WIDTH:  width_reg  <= cfg_data[CFG_DIM_W-1:0];
        REG_HEIGHT: height_reg <= cfg_data[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamping
  logic [CMP_W-1:0] w_raw, h_raw, s_raw, w_c, h_c, s_c;
  logic [S_W-1:0]   s_new;
  logic [AR_W-1:0]  s_ext;

  always_comb begin
    w_raw = CMP_W'(width_reg);
    h_raw = CMP_W'(height_reg);
    s_raw = CMP_W'(shrink_reg);
    if (w_raw == '0) begin
      w_c = CMP_W'(1);
    end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
      w_c = CMP_W'(MAX_WIDTH);
    end else begin
      w_c = w_raw;
    end
    if (h_raw == '0) begin
      h_c = CMP_W'(1);
    end else if (h_raw > CMP_W'(MAX_WIDTH)) begin
      h_c = CMP_W'(MAX_WIDTH);
    end else begin
      h_c = h_raw;
    end
    s_c = s_raw;
    if (s_c == '0) begin
      s_c = CMP_W'(1);
    end
    if (s_c > CMP_W'(MAX_SHRINK)) begin
      s_c = CMP_W'(MAX_SHRINK);
    end
    if (s_c > w_c) begin
      s_c = w_c;
    end
    if (s_c > h_c) begin
      s_c = h_c;
    end
    s_new = S_W'(s_c);
    s_ext = AR_W'(s_new);
  end

  logic [CMP_W-1:0] w_lat, h_lat, out_w, out_h;
  logic [S_W-1:0]   s_lat;
  logic [AR_W-1:0]  area;

  // divider
  logic                          div_done;
  logic [LANES-1:0][DIVN-1:0]    div_a;
  logic [AR_W-1:0]               div_b;
  logic [LANES-1:0][DIVN-1:0]    div_q;
  logic [LANES-1:0][AR_W-1:0]    div_r;

  // position state
  logic [POS_W-1:0] pc, pr, oc, orow;
  logic [PH_W-1:0]  cph, rph;
  logic [S_W-1:0]   cm, rm;

  // stage 1
  logic              p1_valid;
  logic [AW-1:0]     p1_addr;
  logic [PIX_W-1:0]  p1_r, p1_g, p1_b;
  logic              p1_first, p1_last, p1_fwd, p1_done;
  logic [POS_W-1:0]  p1_oc, p1_orow;
  logic [MEM_W-1:0]  rdata, last_sum, base, sum_word;
  logic [SUM_W-1:0]  sum_r, sum_g, sum_b;

  logic [MEM_W-1:0]  mem [MAX_WIDTH];

  // current item, frame_start applied
  logic [POS_W-1:0] pc_e, pr_e, oc_e, orow_e;
  logic [PH_W-1:0]  cph_e, rph_e;
  logic [S_W-1:0]   cm_e, rm_e, s_m1;
  logic             accept, in_blk, blk_first, blk_last, blk_done;
  logic             col_end, row_end, cm_wrap, rm_wrap;
  logic [PH_W-1:0]  cph_inc, rph_inc;
  logic [AW-1:0]    addr_e;

  assign in_stall = !cmd.take_ok;
  assign accept   = in_valid && cmd.take_ok;

  always_comb begin
    pc_e   = frame_start ? '0 : pc;
    pr_e   = frame_start ? '0 : pr;
    oc_e   = frame_start ? '0 : oc;
    orow_e = frame_start ? '0 : orow;
    cph_e  = frame_start ? '0 : cph;
    rph_e  = frame_start ? '0 : rph;
    cm_e   = frame_start ? '0 : cm;
    rm_e   = frame_start ? '0 : rm;
    s_m1   = s_lat - S_W'(1);
    addr_e = AW'(oc_e);

    in_blk = (CMP_W'(oc_e) < out_w) && (CMP_W'(orow_e) < out_h)
             && (CMP_W'(oc_e) < CMP_W'(MAX_WIDTH));
    blk_first = (cph_e == '0) && (rph_e == '0);
    blk_last  = (S_W'(cph_e) == s_m1) && (S_W'(rph_e) == s_m1);
    blk_done  = ((CMP_W'(oc_e) + CMP_W'(1)) == out_w)
                && ((CMP_W'(orow_e) + CMP_W'(1)) == out_h);

    col_end = (CMP_W'(pc_e) + CMP_W'(1)) >= w_lat;
    row_end = (CMP_W'(pr_e) + CMP_W'(1)) >= h_lat;
    // a phase left above S-1 by a register change wraps on its next advance
    cph_inc = ((S_W + 1)'(cph_e) + (S_W + 1)'(1) >= (S_W + 1)'(s_lat))
              ? '0 : PH_W'(cph_e + PH_W'(1));
    rph_inc = ((S_W + 1)'(rph_e) + (S_W + 1)'(1) >= (S_W + 1)'(s_lat))
              ? '0 : PH_W'(rph_e + PH_W'(1));
    cm_wrap = ((cm_e + S_W'(1)) == s_lat);
    rm_wrap = ((rm_e + S_W'(1)) == s_lat);
  end

  // config-derived sizes and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      w_lat <= CMP_W'(1);
      h_lat <= CMP_W'(1);
      s_lat <= S_W'(1);
      area  <= AR_W'(1);
      out_w <= CMP_W'(1);
      out_h <= CMP_W'(1);
      pc    <= '0;
      pr    <= '0;
      oc    <= '0;
      orow  <= '0;
      cph   <= '0;
      rph   <= '0;
      cm    <= '0;
      rm    <= '0;
    end else begin
      if (cmd.cfg_latch) begin
        w_lat <= w_c;
        h_lat <= h_c;
        s_lat <= s_new;
        area  <= s_ext * s_ext;
      end
      if (cmd.store_a) begin
        out_w <= CMP_W'(div_q[0]);
        out_h <= CMP_W'(div_q[1]);
        oc    <= POS_W'(div_q[2]);
        cm    <= S_W'(div_r[2]);
      end else if (cmd.store_b) begin
        orow  <= POS_W'(div_q[0]);
        rm    <= S_W'(div_r[0]);
      end else if (accept) begin
        if (col_end) begin
          pc  <= '0;
          cph <= '0;
          oc  <= '0;
          cm  <= '0;
          if (row_end) begin
            pr   <= '0;
            rph  <= '0;
            orow <= '0;
            rm   <= '0;
          end else begin
            pr  <= pr_e + POS_W'(1);
            rph <= rph_inc;
            if (rm_wrap) begin
              rm   <= '0;
              orow <= orow_e + POS_W'(1);
            end else begin
              rm   <= rm_e + S_W'(1);
              orow <= orow_e;
            end
          end
        end else begin
          pc  <= pc_e + POS_W'(1);
          cph <= cph_inc;
          pr  <= pr_e;
          rph <= rph_e;
          orow <= orow_e;
          rm  <= rm_e;
          if (cm_wrap) begin
            cm <= '0;
            oc <= oc_e + POS_W'(1);
          end else begin
            cm <= cm_e + S_W'(1);
            oc <= oc_e;
          end
        end
      end
    end
  end

  // column sum row: read at accept, written back in the next cycle
  always_ff @(posedge clk) begin
    if (accept && in_blk) begin
      rdata <= mem[addr_e];
    end
    if (p1_valid) begin
      mem[p1_addr] <= sum_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= accept && in_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_blk) begin
      p1_addr  <= addr_e;
      p1_r     <= red_in;
      p1_g     <= green_in;
      p1_b     <= blue_in;
      p1_first <= blk_first;
      p1_last  <= blk_last;
      p1_done  <= blk_done;
      p1_oc    <= oc_e;
      p1_orow  <= orow_e;
      // the entry being written this edge is not yet visible to the read
      p1_fwd   <= p1_valid && (p1_addr == addr_e);
    end
    if (p1_valid) begin
      last_sum <= sum_word;
    end
  end

  always_comb begin
    base = p1_fwd ? last_sum : rdata;
    if (p1_first) begin
      sum_r = SUM_W'(p1_r);
      sum_g = SUM_W'(p1_g);
      sum_b = SUM_W'(p1_b);
    end else begin
      sum_r = base[3*SUM_W-1:2*SUM_W] + SUM_W'(p1_r);
      sum_g = base[2*SUM_W-1:SUM_W]   + SUM_W'(p1_g);
      sum_b = base[SUM_W-1:0]         + SUM_W'(p1_b);
    end
    sum_word = {sum_r, sum_g, sum_b};
  end

  always_comb begin
    case (cmd.div_sel)
      SEL_RES: begin
        div_a[0] = DIVN'(sum_r);
        div_a[1] = DIVN'(sum_g);
        div_a[2] = DIVN'(sum_b);
        div_b    = area;
      end
      SEL_CFG_A: begin
        div_a[0] = DIVN'(w_lat);
        div_a[1] = DIVN'(h_lat);
        div_a[2] = DIVN'(pc);
        div_b    = AR_W'(s_lat);
      end
      SEL_CFG_B: begin
        div_a[0] = DIVN'(pr);
        div_a[1] = '0;
        div_a[2] = '0;
        div_b    = AR_W'(s_lat);
      end
      default: begin
        div_a = '0;
        div_b = AR_W'(1);
      end
    endcase
  end

  bxavg_div #(
    .N (DIVN),
    .D (AR_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // result position, held while the means are divided out
  logic [POS_W-1:0] res_oc, res_orow;
  logic             res_done;

  always_ff @(posedge clk) begin
    if (cmd.div_start && (cmd.div_sel == SEL_RES)) begin
      res_oc   <= p1_oc;
      res_orow <= p1_orow;
      res_done <= p1_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_avg    <= div_q[0][PIX_W-1:0];
      green_avg  <= div_q[1][PIX_W-1:0];
      blue_avg   <= div_q[2][PIX_W-1:0];
      out_column <= res_oc;
      out_row    <= res_orow;
      frame_done <= res_done;
    end
  end

  assign stat.last_pend = p1_valid && p1_last;
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

// ----- rtl/box_average_downscaler_top.sv -----
// Box-average downscaler: shrinks an RGB image by an integer factor S,
// each output pixel being the truncated per-channel mean of an S x S block.
// Input channel: in_valid/in_stall with red_in, green_in, blue_in and
// frame_start (restarts the raster position). Pixels arrive in raster order.
// Output channel: out_valid/out_stall with the three means, the block's
// column and row in the shrunk image, and frame_done on the frame's last one.
// Config: cfg_we/cfg_index/cfg_data (shrink factor, width, height), written
// between frames. Each write starts a size recompute on the shared iterative
// divider, during which in_stall is high.
// Throughput: one pixel per cycle while no block completes. A pixel that
// closes a block stalls the input while the 16-step divider forms the three
// means and until the output register is free to take them. The running
// column sums sit in one read-modify-write memory row with a bypass for
// back-to-back pixels.
// A finished item waits in the output register while new pixels are taken;
// a second result waits in the divider until the receiver frees it.
// Reset: factor, width and height go to 1, position to the frame origin,
// output channel empty. The sum memory needs no clearing.
module box_average_downscaler_top #(
  parameter int MAX_WIDTH  = bxavg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SHRINK = bxavg_pkg::MAX_SHRINK_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bxavg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bxavg_pkg::PIX_W-1:0]      red_in,
  input  logic [bxavg_pkg::PIX_W-1:0]      green_in,
  input  logic [bxavg_pkg::PIX_W-1:0]      blue_in,
  input  logic                             frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bxavg_pkg::PIX_W-1:0]      red_avg,
  output logic [bxavg_pkg::PIX_W-1:0]      green_avg,
  output logic [bxavg_pkg::PIX_W-1:0]      blue_avg,
  output logic [bxavg_pkg::POS_W-1:0]      out_column,
  output logic [bxavg_pkg::POS_W-1:0]      out_row,
  output logic                             frame_done
);
  import bxavg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bxavg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg_we (cfg_we),
    .stat   (stat),
    .cmd    (cmd)
  );

  bxavg_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_SHRINK (MAX_SHRINK)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red_avg     (red_avg),
    .green_avg   (green_avg),
    .blue_avg    (blue_avg),
    .out_column  (out_column),
    .out_row     (out_row),
    .frame_done  (frame_done),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
